### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a reset that disables it.
`define AM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define AM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/drbc_pkg.sv
// Types, codes and fixed widths of the discovery retry and backoff controller.
package drbc_pkg;

  localparam int CMD_W      = 2;
  localparam int NOW_W      = 32;
  localparam int TTL_W      = 22;
  localparam int RND_W      = 8;
  localparam int TPS_W      = 17;
  localparam int SEC_W      = 8;
  localparam int MULT_W     = 10;
  localparam int PHASE_W    = 2;
  localparam int SCHED_W    = 2;
  localparam int WAIT_W     = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // serial multiplier: ttl x tps is the widest product
  localparam int MUL_A_W = TTL_W;
  localparam int MUL_B_W = TPS_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // 800/1000 reduces to 4/5: two extra low bits, then divide by five
  localparam int DIV_PRE   = 2;
  localparam int DIV_W     = PROD_W + DIV_PRE;
  localparam int DIVISOR   = 5;
  localparam int DIV_REM_W = 3;

  // growth factor is in 1/256 units
  localparam int BACKOFF_SHIFT = 8;

  localparam logic [CMD_W-1:0] CMD_POLL  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RETRY = 2'd2;

  localparam logic [SCHED_W-1:0] SCH_NOW  = 2'd0;
  localparam logic [SCHED_W-1:0] SCH_POLL = 2'd1;
  localparam logic [SCHED_W-1:0] SCH_WAIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT = 2'd3;

  localparam logic [TPS_W-1:0]  TPS_RST  = 17'd1000;
  localparam logic [SEC_W-1:0]  INIT_RST = 8'd8;
  localparam logic [SEC_W-1:0]  MAX_RST  = 8'd150;
  localparam logic [MULT_W-1:0] MULT_RST = 10'd352;

  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

### rtl/discovery_retry_backoff_controller.sv
// Top level of the discovery retry and backoff controller.
// One event is handled at a time. Polls outside retry, responses that fail
// and reset events reach the output register through the evaluate and done
// states; a retry poll adds one pass of the serial multiplier for
// backoff x tick rate, and a second pass for the growth step once the wait
// has run out; a good response takes a multiplier pass for TTL x tick rate
// and a bit-serial divide by five before the deadline is set. The
// next beat is taken as soon as the result sits in the output register,
// whether or not it has been collected.
module discovery_retry_backoff_controller #(
  parameter int TIME_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drbc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [drbc_pkg::CMD_W-1:0]      cmd,
  input  logic [drbc_pkg::NOW_W-1:0]      now_ticks,
  input  logic                            browse_ok,
  input  logic                            resp_ok,
  input  logic [drbc_pkg::TTL_W-1:0]      ttl_s,
  input  logic [drbc_pkg::RND_W-1:0]      random_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [drbc_pkg::PHASE_W-1:0]    phase,
  output logic                            data_valid,
  output logic                            browse_issued,
  output logic [drbc_pkg::SCHED_W-1:0]    schedule,
  output logic [drbc_pkg::WAIT_W-1:0]     wait_ticks,
  output logic                            need_random
);

  localparam int DCNT_W = $clog2(drbc_pkg::DIV_W + 1);
  localparam int CMP_W  = (drbc_pkg::DIV_W > TIME_BITS) ? drbc_pkg::DIV_W : TIME_BITS;
  localparam logic [TIME_BITS-1:0] OFF_LIM = {1'b0, {(TIME_BITS-1){1'b1}}};

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EVAL = 8'b0000_0010,
    S_BT   = 8'b0000_0100,
    S_NXT  = 8'b0000_1000,
    S_PROD = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_DEAD = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  function automatic logic tpos(input logic [TIME_BITS-1:0] d);
    tpos = (d != '0) && !d[TIME_BITS-1];
  endfunction

  state_t state, state_next;

  logic [drbc_pkg::TPS_W-1:0]  tps;
  logic [drbc_pkg::SEC_W-1:0]  init_s;
  logic [drbc_pkg::SEC_W-1:0]  max_s;
  logic [drbc_pkg::MULT_W-1:0] mult;

  logic [drbc_pkg::PHASE_W-1:0] phase_reg, phase_reg_next;
  logic [drbc_pkg::SEC_W-1:0]   backoff, backoff_next;
  logic [TIME_BITS-1:0]         deadline, deadline_next;
  logic [TIME_BITS-1:0]         last_done, last_done_next;

  logic [drbc_pkg::CMD_W-1:0] cmd_q;
  logic [TIME_BITS-1:0]       now_q;
  logic                       bok_q;
  logic                       rok_q;
  logic [drbc_pkg::TTL_W-1:0] ttl_q;
  logic [drbc_pkg::RND_W-1:0] rnd_q;

  logic                         res_issued, res_issued_next;
  logic [drbc_pkg::SCHED_W-1:0] res_sched, res_sched_next;
  logic [drbc_pkg::WAIT_W-1:0]  res_wait, res_wait_next;
  logic                         res_needr, res_needr_next;

  logic [drbc_pkg::DIV_W-1:0]     div_sh;
  logic [drbc_pkg::DIV_REM_W-1:0] div_rem;
  logic [drbc_pkg::DIV_W-1:0]     quo;
  logic [DCNT_W-1:0]              div_cnt;
  logic [drbc_pkg::DIV_REM_W:0]   div_part;
  logic                           div_ge;
  logic [drbc_pkg::DIV_REM_W:0]   div_left;

  drbc_pkg::mul_req_t mreq;
  drbc_pkg::mul_rsp_t mrsp;

  logic [TIME_BITS-1:0]         rem;
  logic [63:0]                  rem_wide;
  logic [drbc_pkg::MULT_W-1:0]  nxt;
  logic [TIME_BITS-1:0]         off;
  logic                         load_out;

  drbc_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    div_part = {div_rem, div_sh[drbc_pkg::DIV_W-1]};
    div_ge   = div_part >= (drbc_pkg::DIV_REM_W+1)'(drbc_pkg::DIVISOR);
    div_left = div_ge ? div_part - (drbc_pkg::DIV_REM_W+1)'(drbc_pkg::DIVISOR) : div_part;
  end

  always_comb begin
    rem      = last_done + TIME_BITS'(mrsp.prod) - now_q;
    rem_wide = 64'(rem);
    nxt      = mrsp.prod[drbc_pkg::MULT_W+drbc_pkg::BACKOFF_SHIFT-1:drbc_pkg::BACKOFF_SHIFT];
    off      = (CMP_W'(quo) > CMP_W'(OFF_LIM)) ? OFF_LIM : TIME_BITS'(quo);
  end

  always_comb begin
    state_next      = state;
    phase_reg_next  = phase_reg;
    backoff_next    = backoff;
    deadline_next   = deadline;
    last_done_next  = last_done;
    res_issued_next = res_issued;
    res_sched_next  = res_sched;
    res_wait_next   = res_wait;
    res_needr_next  = res_needr;
    mreq.start      = 1'b0;
    mreq.a          = '0;
    mreq.b          = '0;
    load_out        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        res_issued_next = 1'b0;
        res_sched_next  = drbc_pkg::SCH_NOW;
        res_wait_next   = '0;
        res_needr_next  = 1'b0;
        state_next      = S_DONE;
        case (cmd_q)
          drbc_pkg::CMD_POLL: begin
            case (phase_reg)
              drbc_pkg::PH_IDLE: begin
                if (!tpos(deadline - now_q)) begin
                  if (bok_q) begin
                    phase_reg_next  = drbc_pkg::PH_WAIT;
                    res_issued_next = 1'b1;
                  end
                  res_sched_next = drbc_pkg::SCH_POLL;
                end
              end
              drbc_pkg::PH_WAIT: begin
                res_sched_next = drbc_pkg::SCH_POLL;
              end
              default: begin
                mreq.start = 1'b1;
                mreq.a     = drbc_pkg::MUL_A_W'(tps);
                mreq.b     = drbc_pkg::MUL_B_W'(backoff);
                state_next = S_BT;
              end
            endcase
          end
          drbc_pkg::CMD_RESP: begin
            if (phase_reg == drbc_pkg::PH_WAIT) begin
              if (rok_q) begin
                mreq.start = 1'b1;
                mreq.a     = drbc_pkg::MUL_A_W'(ttl_q);
                mreq.b     = drbc_pkg::MUL_B_W'(tps);
                state_next = S_PROD;
              end else begin
                phase_reg_next = drbc_pkg::PH_RETRY;
                last_done_next = now_q;
              end
            end
          end
          drbc_pkg::CMD_RESET: begin
            phase_reg_next = drbc_pkg::PH_IDLE;
            backoff_next   = init_s;
            deadline_next  = now_q;
            last_done_next = now_q;
          end
          default: begin
          end
        endcase
      end
      S_BT: begin
        if (mrsp.done) begin
          if (tpos(rem)) begin
            res_sched_next = drbc_pkg::SCH_WAIT;
            res_wait_next  = (rem_wide > 64'(drbc_pkg::WAIT_MAX)) ? drbc_pkg::WAIT_MAX
                                                                   : rem_wide[drbc_pkg::WAIT_W-1:0];
            state_next     = S_DONE;
          end else begin
            mreq.start = 1'b1;
            mreq.a     = drbc_pkg::MUL_A_W'(mult);
            mreq.b     = drbc_pkg::MUL_B_W'(backoff);
            state_next = S_NXT;
          end
        end
      end
      S_NXT: begin
        if (mrsp.done) begin
          state_next = S_DONE;
          if (nxt <= drbc_pkg::MULT_W'(max_s)) begin
            backoff_next   = nxt[drbc_pkg::SEC_W-1:0];
            phase_reg_next = drbc_pkg::PH_IDLE;
            res_sched_next = drbc_pkg::SCH_POLL;
          end else if (rnd_q >= init_s && rnd_q <= max_s) begin
            backoff_next   = rnd_q;
            phase_reg_next = drbc_pkg::PH_IDLE;
            res_sched_next = drbc_pkg::SCH_POLL;
          end else begin
            res_needr_next = 1'b1;
            res_sched_next = drbc_pkg::SCH_NOW;
          end
        end
      end
      S_PROD: begin
        if (mrsp.done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt == DCNT_W'(1)) begin
          state_next = S_DEAD;
        end
      end
      S_DEAD: begin
        deadline_next  = now_q + off;
        phase_reg_next = drbc_pkg::PH_IDLE;
        backoff_next   = init_s;
        last_done_next = now_q;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tps       <= drbc_pkg::TPS_RST;
      init_s    <= drbc_pkg::INIT_RST;
      max_s     <= drbc_pkg::MAX_RST;
      mult      <= drbc_pkg::MULT_RST;
      phase_reg <= drbc_pkg::PH_IDLE;
      backoff   <= drbc_pkg::INIT_RST;
      deadline  <= '0;
      last_done <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase_reg <= phase_reg_next;
      backoff   <= backoff_next;
      deadline  <= deadline_next;
      last_done <= last_done_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          drbc_pkg::CFG_TPS:  tps    <= cfg_data;
          drbc_pkg::CFG_INIT: init_s <= cfg_data[drbc_pkg::SEC_W-1:0];
          drbc_pkg::CFG_MAX:  max_s  <= cfg_data[drbc_pkg::SEC_W-1:0];
          drbc_pkg::CFG_MULT: mult   <= cfg_data[drbc_pkg::MULT_W-1:0];
          default: begin
          end
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q <= cmd;
      now_q <= TIME_BITS'(now_ticks);
      bok_q <= browse_ok;
      rok_q <= resp_ok;
      ttl_q <= ttl_s;
      rnd_q <= random_byte;
    end
    res_issued <= res_issued_next;
    res_sched  <= res_sched_next;
    res_wait   <= res_wait_next;
    res_needr  <= res_needr_next;
    if (state == S_PROD && mrsp.done) begin
      div_sh  <= {mrsp.prod, drbc_pkg::DIV_PRE'(0)};
      div_rem <= '0;
      quo     <= '0;
      div_cnt <= DCNT_W'(drbc_pkg::DIV_W);
    end else if (state == S_DIV) begin
      div_sh  <= {div_sh[drbc_pkg::DIV_W-2:0], 1'b0};
      div_rem <= div_left[drbc_pkg::DIV_REM_W-1:0];
      quo     <= {quo[drbc_pkg::DIV_W-2:0], div_ge};
      div_cnt <= div_cnt - DCNT_W'(1);
    end
    if (load_out) begin
      phase         <= phase_reg;
      data_valid    <= (phase_reg == drbc_pkg::PH_IDLE) && tpos(deadline - now_q);
      browse_issued <= res_issued;
      schedule      <= res_sched;
      wait_ticks    <= res_wait;
      need_random   <= res_needr;
    end
  end

endmodule

### rtl/drbc_serial_mul.sv
// Shift-add multiplier taking one bit of the second operand per cycle.
module drbc_serial_mul (
  input  logic               clk,
  input  logic               rst,
  input  drbc_pkg::mul_req_t req,
  output drbc_pkg::mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(drbc_pkg::MUL_B_W + 1);

  logic                         busy;
  logic                         done;
  logic [CNT_W-1:0]             cnt;
  logic [drbc_pkg::MUL_A_W-1:0] a_q;
  logic [drbc_pkg::MUL_B_W-1:0] bsh;
  logic [drbc_pkg::PROD_W-1:0]  acc;
  logic [drbc_pkg::PROD_W-1:0]  acc_next;

  always_comb begin
    acc_next = {acc[drbc_pkg::PROD_W-2:0], 1'b0} +
               (bsh[drbc_pkg::MUL_B_W-1] ? drbc_pkg::PROD_W'(a_q) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(drbc_pkg::MUL_B_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_q <= req.a;
      bsh <= req.b;
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      bsh <= {bsh[drbc_pkg::MUL_B_W-2:0], 1'b0};
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.prod = acc;
  end

endmodule

### rtl/drbc_checker.sv
// Port-level checker of the discovery retry and backoff controller, with its bind.
`include "assert_macros.svh"

module drbc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [drbc_pkg::PHASE_W-1:0] phase,
  input logic                         data_valid,
  input logic                         browse_issued,
  input logic [drbc_pkg::SCHED_W-1:0] schedule,
  input logic [drbc_pkg::WAIT_W-1:0]  wait_ticks,
  input logic                         need_random
);

  `AM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result beat dropped")
  `AM_ASSERT(a_one_at_a_time, clk, rst, in_valid && in_ready |=> !in_ready, "second beat taken early")
  `AM_ASSERT(a_valid_idle, clk, rst, out_valid && data_valid |-> phase == drbc_pkg::PH_IDLE, "data valid outside idle")
  `AM_ASSERT(a_issue, clk, rst, out_valid && browse_issued |-> phase == drbc_pkg::PH_WAIT && schedule == drbc_pkg::SCH_POLL, "bad browse result")
  `AM_ASSERT(a_needr, clk, rst, out_valid && need_random |-> phase == drbc_pkg::PH_RETRY && schedule == drbc_pkg::SCH_NOW && wait_ticks == '0, "bad random request")

endmodule

bind discovery_retry_backoff_controller drbc_checker u_drbc_checker (.*);

### sim/tb_top.sv
// Self-checking testbench of the discovery retry and backoff controller.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [drbc_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int NUM_SETTINGS = 6;

  typedef struct packed {
    logic [drbc_pkg::PHASE_W-1:0] ph;
    logic                         fresh;
    logic                         issued;
    logic [drbc_pkg::SCHED_W-1:0] sched;
    logic [drbc_pkg::WAIT_W-1:0]  wait_len;
    logic                         retry_rnd;
  } lookup_outcome_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [drbc_pkg::CFG_IDX_W-1:0] cfg_index = drbc_pkg::CFG_TPS;
  logic [drbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [drbc_pkg::CMD_W-1:0] cmd = drbc_pkg::CMD_POLL;
  logic [drbc_pkg::NOW_W-1:0] now_ticks = '0;
  logic browse_ok = 1'b0;
  logic resp_ok = 1'b0;
  logic [drbc_pkg::TTL_W-1:0] ttl_s = '0;
  logic [drbc_pkg::RND_W-1:0] random_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [drbc_pkg::PHASE_W-1:0] phase;
  logic data_valid;
  logic browse_issued;
  logic [drbc_pkg::SCHED_W-1:0] schedule;
  logic [drbc_pkg::WAIT_W-1:0] wait_ticks;
  logic need_random;

  // register shadows and client state
  logic [drbc_pkg::TPS_W-1:0] reg_tps = drbc_pkg::TPS_RST;
  logic [drbc_pkg::SEC_W-1:0] reg_init = drbc_pkg::INIT_RST;
  logic [drbc_pkg::SEC_W-1:0] reg_max = drbc_pkg::MAX_RST;
  logic [drbc_pkg::MULT_W-1:0] reg_mult = drbc_pkg::MULT_RST;
  logic [drbc_pkg::PHASE_W-1:0] st_phase = drbc_pkg::PH_IDLE;
  logic [drbc_pkg::SEC_W-1:0] st_backoff = drbc_pkg::INIT_RST;
  logic [drbc_pkg::NOW_W-1:0] st_deadline = '0;
  logic [drbc_pkg::NOW_W-1:0] st_last_done = '0;

  lookup_outcome_t pending_outcomes[$];
  lookup_outcome_t head_outcome;
  logic [drbc_pkg::NOW_W-1:0] clock_now = '0;
  logic receiver_held = 1'b0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int error_count = 0;
  int events_sent = 0;
  int results_checked = 0;

  discovery_retry_backoff_controller u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .now_ticks(now_ticks),
    .browse_ok(browse_ok), .resp_ok(resp_ok), .ttl_s(ttl_s), .random_byte(random_byte),
    .out_valid(out_valid), .out_ready(out_ready), .phase(phase), .data_valid(data_valid),
    .browse_issued(browse_issued), .schedule(schedule), .wait_ticks(wait_ticks),
    .need_random(need_random)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit ahead(logic [drbc_pkg::NOW_W-1:0] d);
    return d != '0 && !d[drbc_pkg::NOW_W-1];
  endfunction

  function automatic lookup_outcome_t advance_client(logic [drbc_pkg::CMD_W-1:0] c,
      logic [drbc_pkg::NOW_W-1:0] t, logic bok, logic rok, logic [drbc_pkg::TTL_W-1:0] ttl,
      logic [drbc_pkg::RND_W-1:0] rnd);
    lookup_outcome_t o;
    logic [drbc_pkg::NOW_W-1:0] rem;
    logic [63:0] off;
    logic [17:0] grown;
    o = '0;
    case (c)
      drbc_pkg::CMD_POLL: begin
        if (st_phase == drbc_pkg::PH_IDLE) begin
          if (ahead(st_deadline - t)) begin
            o.sched = drbc_pkg::SCH_NOW;
          end else begin
            if (bok) begin
              st_phase = drbc_pkg::PH_WAIT;
              o.issued = 1'b1;
            end
            o.sched = drbc_pkg::SCH_POLL;
          end
        end else if (st_phase == drbc_pkg::PH_WAIT) begin
          o.sched = drbc_pkg::SCH_POLL;
        end else begin
          rem = st_last_done + 32'(st_backoff) * 32'(reg_tps) - t;
          if (ahead(rem)) begin
            o.sched = drbc_pkg::SCH_WAIT;
            o.wait_len = rem[drbc_pkg::WAIT_W-1:0];
          end else begin
            grown = (18'(st_backoff) * 18'(reg_mult)) >> drbc_pkg::BACKOFF_SHIFT;
            if (grown <= 18'(reg_max)) begin
              st_backoff = grown[drbc_pkg::SEC_W-1:0];
              st_phase = drbc_pkg::PH_IDLE;
              o.sched = drbc_pkg::SCH_POLL;
            end else if (rnd >= reg_init && rnd <= reg_max) begin
              st_backoff = rnd;
              st_phase = drbc_pkg::PH_IDLE;
              o.sched = drbc_pkg::SCH_POLL;
            end else begin
              o.retry_rnd = 1'b1;
              o.sched = drbc_pkg::SCH_NOW;
            end
          end
        end
      end
      drbc_pkg::CMD_RESP: begin
        if (st_phase == drbc_pkg::PH_WAIT) begin
          if (rok) begin
            off = (64'(ttl) * 64'd800 * 64'(reg_tps)) / 64'd1000;
            if (off > 64'h7FFF_FFFF) off = 64'h7FFF_FFFF;
            st_deadline = t + off[drbc_pkg::NOW_W-1:0];
            st_phase = drbc_pkg::PH_IDLE;
            st_backoff = reg_init;
          end else begin
            st_phase = drbc_pkg::PH_RETRY;
          end
          st_last_done = t;
        end
      end
      drbc_pkg::CMD_RESET: begin
        st_phase = drbc_pkg::PH_IDLE;
        st_backoff = reg_init;
        st_deadline = t;
        st_last_done = t;
      end
      default: ;
    endcase
    o.ph = st_phase;
    o.fresh = (st_phase == drbc_pkg::PH_IDLE) && ahead(st_deadline - t);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result beat", 64'd0, 64'd0);
      end else begin
        head_outcome = pending_outcomes.pop_front();
        if (phase !== head_outcome.ph)
          report_mismatch("phase", 64'(head_outcome.ph), 64'(phase));
        if (data_valid !== head_outcome.fresh)
          report_mismatch("data_valid", 64'(head_outcome.fresh), 64'(data_valid));
        if (browse_issued !== head_outcome.issued)
          report_mismatch("browse_issued", 64'(head_outcome.issued), 64'(browse_issued));
        if (schedule !== head_outcome.sched)
          report_mismatch("schedule", 64'(head_outcome.sched), 64'(schedule));
        if (wait_ticks !== head_outcome.wait_len)
          report_mismatch("wait_ticks", 64'(head_outcome.wait_len), 64'(wait_ticks));
        if (need_random !== head_outcome.retry_rnd)
          report_mismatch("need_random", 64'(head_outcome.retry_rnd), 64'(need_random));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || receiver_held) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic hold_receiver(int cycles);
    receiver_held <= 1'b1;
    repeat (cycles) @(posedge clk);
    receiver_held <= 1'b0;
  endtask

  task automatic send_event(logic [drbc_pkg::CMD_W-1:0] c, logic [drbc_pkg::NOW_W-1:0] t,
      logic bok, logic rok, logic [drbc_pkg::TTL_W-1:0] ttl, logic [drbc_pkg::RND_W-1:0] rnd);
    int gap;
    gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    now_ticks <= t;
    browse_ok <= bok;
    resp_ok <= rok;
    ttl_s <= ttl;
    random_byte <= rnd;
    do @(posedge clk); while (!in_ready);
    pending_outcomes.push_back(advance_client(c, t, bok, rok, ttl, rnd));
    events_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [drbc_pkg::CFG_IDX_W-1:0] idx,
      logic [drbc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      drbc_pkg::CFG_TPS:  reg_tps = val[drbc_pkg::TPS_W-1:0];
      drbc_pkg::CFG_INIT: reg_init = val[drbc_pkg::SEC_W-1:0];
      drbc_pkg::CFG_MAX:  reg_max = val[drbc_pkg::SEC_W-1:0];
      drbc_pkg::CFG_MULT: reg_mult = val[drbc_pkg::MULT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_registers(int tps_v, int init_v, int ceil_v, int mult_v);
    settle();
    write_register(drbc_pkg::CFG_TPS, drbc_pkg::CFG_DATA_W'(tps_v));
    write_register(drbc_pkg::CFG_INIT, drbc_pkg::CFG_DATA_W'(init_v));
    write_register(drbc_pkg::CFG_MAX, drbc_pkg::CFG_DATA_W'(ceil_v));
    write_register(drbc_pkg::CFG_MULT, drbc_pkg::CFG_DATA_W'(mult_v));
  endtask

  task automatic apply_setting(int k);
    case (k)
      0: apply_registers(1000, 8, 150, 352);
      1: apply_registers(1, 1, 1, 256);
      2: apply_registers(65536, 254, 254, 1023);
      3: apply_registers(7, 3, 40, 600);
      4: apply_registers(50, 60, 20, 300);   // initial above max: no byte accepted
      default: apply_registers(3, 1, 254, 1023);
    endcase
  endtask

  // mostly well-formed lookup flows steered by the client state, some noise
  task automatic random_event();
    logic [drbc_pkg::CMD_W-1:0] c;
    logic bok;
    logic rok;
    logic [drbc_pkg::TTL_W-1:0] ttl;
    logic [drbc_pkg::RND_W-1:0] rnd;
    int roll;
    bok = $urandom_range(99) < 70;
    rok = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1: ttl = drbc_pkg::TTL_W'($urandom_range(0, 32'h3F_FFFF));
      2: ttl = '1;
      default: ttl = drbc_pkg::TTL_W'($urandom_range(0, 200));
    endcase
    rnd = drbc_pkg::RND_W'($urandom_range(0, 255));
    if (st_phase == drbc_pkg::PH_RETRY && $urandom_range(3) == 0) begin
      // land on the expiry edge of the backoff
      clock_now = st_last_done + 32'(st_backoff) * 32'(reg_tps) + $urandom_range(0, 2) - 1;
    end else begin
      case ($urandom_range(2))
        0: clock_now += $urandom_range(0, 3);
        1: clock_now += $urandom_range(0, 3000);
        default: clock_now += 32'($urandom_range(0, 64)) * 32'(reg_tps);
      endcase
    end
    roll = $urandom_range(99);
    if (roll < 8) begin
      send_event(drbc_pkg::CMD_W'($urandom_range(3)), $urandom(), bok, rok, ttl, rnd);
    end else begin
      roll = $urandom_range(99);
      case (st_phase)
        drbc_pkg::PH_IDLE: c = roll < 85 ? drbc_pkg::CMD_POLL
                             : (roll < 92 ? drbc_pkg::CMD_RESP : drbc_pkg::CMD_RESET);
        drbc_pkg::PH_WAIT: c = roll < 80 ? drbc_pkg::CMD_RESP
                             : (roll < 97 ? drbc_pkg::CMD_POLL : drbc_pkg::CMD_RESET);
        default: c = roll < 92 ? drbc_pkg::CMD_POLL
                   : (roll < 96 ? drbc_pkg::CMD_RESP : drbc_pkg::CMD_RESET);
      endcase
      send_event(c, clock_now, bok, rok, ttl, rnd);
    end
  endtask

  task automatic test_directed_defaults();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_event(CMD_SPARE, 32'd5, 1'b1, 1'b1, '1, 8'hFF);
    send_event(drbc_pkg::CMD_RESP, 32'd10, 1'b0, 1'b1, 22'd5, 8'd0);      // dropped while idle
    send_event(drbc_pkg::CMD_POLL, 32'd20, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd30, 1'b1, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd40, 1'b1, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_RESP, 32'd100, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd100, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd8099, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd8100, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd8200, 1'b1, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_RESP, 32'd8300, 1'b0, 1'b1, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd8300, 1'b1, 1'b0, '0, 8'd0);
    // deadline saturates, wraps
    send_event(drbc_pkg::CMD_RESP, 32'hFFFF_FF00, 1'b0, 1'b1, '1, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'h0000_1000, 1'b1, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_RESET, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd0, 1'b1, 1'b0, '0, 8'd0);
  endtask

  task automatic test_random_byte_bounds();
    apply_registers(1, 100, 120, 1023);
    send_event(drbc_pkg::CMD_RESET, 32'd0, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd1, 1'b1, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_RESP, 32'd2, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd102, 1'b0, 1'b0, '0, 8'd99);
    send_event(drbc_pkg::CMD_POLL, 32'd103, 1'b0, 1'b0, '0, 8'd121);
    send_event(drbc_pkg::CMD_POLL, 32'd104, 1'b0, 1'b0, '0, 8'd100);
    send_event(drbc_pkg::CMD_POLL, 32'd105, 1'b1, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_RESP, 32'd106, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd300, 1'b0, 1'b0, '0, 8'd120);
    apply_registers(1, 200, 100, 256);
    send_event(drbc_pkg::CMD_RESET, 32'd400, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd401, 1'b1, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_RESP, 32'd402, 1'b0, 1'b0, '0, 8'd0);
    send_event(drbc_pkg::CMD_POLL, 32'd700, 1'b0, 1'b0, '0, 8'd150);
    send_event(drbc_pkg::CMD_POLL, 32'd701, 1'b0, 1'b0, '0, 8'd255);
  endtask

  task automatic test_random_traffic(int src_pct, int snk_pct, int per_setting);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int k = 0; k < NUM_SETTINGS; k++) begin
      apply_setting(k);
      clock_now = $urandom();
      repeat (per_setting) random_event();
    end
  endtask

  task automatic test_output_holdoff();
    apply_setting(0);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    fork
      hold_receiver(400);
    join_none
    repeat (40) random_event();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_random_byte_bounds();
    test_random_traffic(15, 75, 84);
    test_random_traffic(75, 15, 84);
    test_random_traffic(0, 0, 84);
    test_output_holdoff();
    settle();
    $display("Covered %0d events and %0d checked results with %0d mismatches,", events_sent,
             results_checked, error_count);
    $display("over six register settings, three idling mixes and one long output stall.");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("timeout with %0d results outstanding", pending_outcomes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
